[design/dirty_history_tracker_assert.svh]
// assertion macros for the dirty history tracker
`ifndef DIRTY_HISTORY_TRACKER_ASSERT_SVH
`define DIRTY_HISTORY_TRACKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DHT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dirty history tracker check failed");

// antecedent implies consequent in the next cycle
`define DHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dirty history tracker check failed");

`endif

[design/dht_pkg.sv]
// shared types for the dirty history tracker
package dht_pkg;

  localparam int GenW  = 64;
  localparam int MaskW = 64;

  // request kinds
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // one history entry held by a cell
  typedef struct packed {
    logic             valid;
    logic [GenW-1:0]  gen;
    logic [MaskW-1:0] mask;
    logic             tf;
  } dht_entry_t;

  // per cell control
  typedef struct packed {
    logic shift;
    logic clear;
  } dht_cell_ctrl_t;

endpackage

[design/dht_cell.sv]
// one cell of the history ring: holds an entry and passes it on when shifted
module dht_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  dht_pkg::dht_cell_ctrl_t ctrl,
  input  dht_pkg::dht_entry_t   d,
  output dht_pkg::dht_entry_t   q
);

  logic                      entry_valid;
  logic [dht_pkg::GenW-1:0]  entry_gen;
  logic [dht_pkg::MaskW-1:0] entry_mask;
  logic                      entry_tf;

  // valid bit, cleared by reset and by a history clear
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (ctrl.clear) begin
      entry_valid <= 1'b0;
    end else if (ctrl.shift) begin
      entry_valid <= d.valid;
    end
  end

  // payload taken from the neighbour
  always_ff @(posedge clk) begin
    if (ctrl.shift && !ctrl.clear) begin
      entry_gen  <= d.gen;
      entry_mask <= d.mask;
      entry_tf   <= d.tf;
    end
  end

  assign q.valid = entry_valid;
  assign q.gen   = entry_gen;
  assign q.mask  = entry_mask;
  assign q.tf    = entry_tf;

endmodule

[design/dirty_history_tracker.sv]
// top level of the dirty history tracker: control, ring of cells, result register
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------------------
//   in      | in_valid, in_stall  | req_type, change_mask, change_transform, seen_generation
//   out     | out_valid, out_stall| union_mask, union_transform, current_generation
//
// a record steps through accept, counter update with ring shift, result register load
// a query steps through accept, subtract, a scan of every cell as the ring rotates past
// the tail comparator, result register load
// one request at a time; in_stall is high from acceptance until the result is loaded
// reset is synchronous; it clears the counter and every cell valid bit at once
// a stalled output holds its result and the next result waits in the done state
module dirty_history_tracker #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [63:0] change_mask,
  input  logic        change_transform,
  input  logic [63:0] seen_generation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] union_mask,
  output logic        union_transform,
  output logic [63:0] current_generation
);

  localparam int CntW   = $clog2(HISTORY_DEPTH);
  localparam int FoundW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_REC   = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } dht_state_t;

  dht_state_t state;
  dht_state_t state_next;

  logic        req_kind;
  logic [63:0] req_mask;
  logic        req_tf;
  logic [63:0] req_seen;
  logic [63:0] count;
  logic [63:0] diff;
  logic        ahead;
  logic [CntW-1:0]   scan_cnt;
  logic [FoundW-1:0] found;
  logic [63:0] acc_mask;
  logic        acc_tf;

  dht_pkg::dht_entry_t     cell_q    [HISTORY_DEPTH];
  dht_pkg::dht_entry_t     cell_d    [HISTORY_DEPTH];
  dht_pkg::dht_cell_ctrl_t cell_ctrl [HISTORY_DEPTH];
  dht_pkg::dht_entry_t     head_d;

  logic        in_take;
  logic        out_free;
  logic [63:0] gen_inc;
  logic        wrap;
  logic [63:0] gen_new;
  logic        shift_all;
  logic        wrap_clear;
  logic        head_match;
  logic        last_scan;
  logic        res_cur;
  logic        res_bad;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next generation and wrap detection
  assign gen_inc = count + 64'd1;
  assign wrap    = (gen_inc == 64'd0);
  assign gen_new = wrap ? 64'd1 : gen_inc;

  // ring control: record shifts in a new entry, scan rotates the ring
  assign shift_all  = (state == S_REC) || (state == S_SCAN);
  assign wrap_clear = (state == S_REC) && wrap;

  always_comb begin
    if (state == S_REC) begin
      head_d.valid = 1'b1;
      head_d.gen   = gen_new;
      head_d.mask  = req_mask;
      head_d.tf    = req_tf;
    end else begin
      head_d = cell_q[HISTORY_DEPTH-1];
    end
  end

  // chain of cells
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_d[i]          = head_d;
      assign cell_ctrl[i].clear = 1'b0;
    end else begin : g_body
      assign cell_d[i]          = cell_q[i-1];
      assign cell_ctrl[i].clear = wrap_clear;
    end
    assign cell_ctrl[i].shift = shift_all;

    dht_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (cell_ctrl[i]),
      .d    (cell_d[i]),
      .q    (cell_q[i])
    );
  end

  // tail comparator: entry lies in (seen, count]
  assign head_match = cell_q[HISTORY_DEPTH-1].valid &&
                      (cell_q[HISTORY_DEPTH-1].gen > req_seen) &&
                      (cell_q[HISTORY_DEPTH-1].gen <= count);
  assign last_scan  = (scan_cnt == CntW'(HISTORY_DEPTH - 1));

  // final decision for a query
  assign res_cur = (diff == 64'd0);
  assign res_bad = ahead || (diff > 64'(HISTORY_DEPTH)) || (64'(found) != diff);

  // state sequencing
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = (req_type == dht_pkg::REQ_RECORD) ? S_REC : S_CHECK;
        end
      end
      S_REC:   state_next = S_DONE;
      S_CHECK: state_next = S_SCAN;
      S_SCAN: begin
        if (last_scan) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_kind <= req_type;
      req_mask <= change_mask;
      req_tf   <= change_transform;
      req_seen <= seen_generation;
    end
  end

  // generation counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 64'd0;
    end else if (state == S_REC) begin
      count <= gen_new;
    end
  end

  // distance to the current generation
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      {ahead, diff} <= {1'b0, count} - {1'b0, req_seen};
    end
  end

  // scan accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      found    <= '0;
      acc_mask <= 64'd0;
      acc_tf   <= 1'b0;
    end else if (state == S_CHECK) begin
      scan_cnt <= '0;
      found    <= '0;
      acc_mask <= 64'd0;
      acc_tf   <= 1'b0;
    end else if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + CntW'(1);
      if (head_match) begin
        found    <= found + FoundW'(1);
        acc_mask <= acc_mask | cell_q[HISTORY_DEPTH-1].mask;
        acc_tf   <= acc_tf | cell_q[HISTORY_DEPTH-1].tf;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      current_generation <= count;
      if (req_kind == dht_pkg::REQ_RECORD || res_cur) begin
        union_mask      <= 64'd0;
        union_transform <= 1'b0;
      end else if (res_bad) begin
        union_mask      <= ~64'd0;
        union_transform <= 1'b1;
      end else begin
        union_mask      <= acc_mask;
        union_transform <= acc_tf;
      end
    end
  end

`include "dirty_history_tracker_assert.svh"

  `DHT_ASSERT_NEXT(a_count_nonzero, count != 64'd0, count != 64'd0)
  `DHT_ASSERT_NEXT(a_take_starts, in_take, state == S_REC || state == S_CHECK)
  `DHT_ASSERT_SAME(a_found_bound, 1'b1, found <= FoundW'(HISTORY_DEPTH))

endmodule

[tb/tb_dirty_history_tracker.sv]
// self-checking testbench for the dirty history tracker: directed and random requests
module tb_dirty_history_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HISTORY_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [dht_pkg::MaskW-1:0] ALL_DIRTY = '1;

  // one expected answer
  typedef struct packed {
    logic [dht_pkg::MaskW-1:0] mask;
    logic tf;
    logic [dht_pkg::GenW-1:0] gen;
  } tracker_answer_t;

  // generation history mirror and the queue of answers still owed
  class history_board;
    logic [dht_pkg::GenW-1:0] generation;
    int unsigned write_slot;
    logic [dht_pkg::GenW-1:0] slot_gen [HISTORY_DEPTH];
    logic [dht_pkg::MaskW-1:0] slot_mask [HISTORY_DEPTH];
    logic slot_tf [HISTORY_DEPTH];
    tracker_answer_t pending_answers [$];
    int errors;
    int records;
    int queries;
    int dirty_all;
    int exact_unions;

    function new();
      generation = '0;
      clear_history();
      errors = 0;
      records = 0;
      queries = 0;
      dirty_all = 0;
      exact_unions = 0;
    endfunction

    function void clear_history();
      foreach (slot_gen[i]) begin
        slot_gen[i] = '0;
        slot_mask[i] = '0;
        slot_tf[i] = 1'b0;
      end
      write_slot = 0;
    endfunction

    // update the mirror for an accepted request and queue its answer
    function void note_request(logic rt, logic [dht_pkg::MaskW-1:0] mask, logic tf,
                               logic [dht_pkg::GenW-1:0] seen);
      tracker_answer_t ans;
      logic [dht_pkg::MaskW-1:0] acc;
      logic acc_tf;
      logic [dht_pkg::GenW-1:0] found;
      ans = '0;
      if (rt == dht_pkg::REQ_RECORD) begin
        records++;
        generation = generation + 1'b1;
        // wrap restarts at one with an empty ring
        if (generation == '0) begin
          generation = dht_pkg::GenW'(1);
          clear_history();
        end
        slot_gen[write_slot] = generation;
        slot_mask[write_slot] = mask;
        slot_tf[write_slot] = tf;
        write_slot = (write_slot + 1) % HISTORY_DEPTH;
      end else begin
        queries++;
        if (seen != generation) begin
          if (seen > generation ||
              generation - seen > dht_pkg::GenW'(HISTORY_DEPTH)) begin
            ans.mask = ALL_DIRTY;
            ans.tf = 1'b1;
          end else begin
            acc = '0;
            acc_tf = 1'b0;
            found = '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
              if (slot_gen[i] > seen && slot_gen[i] <= generation) begin
                acc |= slot_mask[i];
                acc_tf |= slot_tf[i];
                found++;
              end
            end
            // a gap in the window means the history cannot tell
            if (found != generation - seen) begin
              ans.mask = ALL_DIRTY;
              ans.tf = 1'b1;
            end else begin
              ans.mask = acc;
              ans.tf = acc_tf;
              exact_unions++;
            end
          end
          if (ans.mask == ALL_DIRTY && ans.tf) dirty_all++;
        end
      end
      ans.gen = generation;
      pending_answers.insert(pending_answers.size(), ans);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s expected %h got %h", $time, what, want, got);
    endfunction

    // compare one delivered result with the oldest answer owed
    function void check_result(logic [dht_pkg::MaskW-1:0] mask, logic tf,
                               logic [dht_pkg::GenW-1:0] gen);
      tracker_answer_t want;
      if (pending_answers.size() == 0) begin
        report("unrequested result, generation", '0, gen);
        return;
      end
      want = pending_answers.pop_front();
      if (mask !== want.mask) report("union_mask", want.mask, mask);
      if (tf !== want.tf) report("union_transform", 64'(want.tf), 64'(tf));
      if (gen !== want.gen) report("current_generation", want.gen, gen);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = dht_pkg::REQ_RECORD;
  logic [dht_pkg::MaskW-1:0] change_mask = '0;
  logic change_transform = 1'b0;
  logic [dht_pkg::GenW-1:0] seen_generation = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [dht_pkg::MaskW-1:0] union_mask;
  logic union_transform;
  logic [dht_pkg::GenW-1:0] current_generation;

  history_board board;
  int cycle_count = 0;
  int stall_left = 0;
  int stall_mode = 0;

  dirty_history_tracker #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .change_mask(change_mask),
    .change_transform(change_transform),
    .seen_generation(seen_generation),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .union_mask(union_mask),
    .union_transform(union_transform),
    .current_generation(current_generation)
  );

  always #6 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(union_mask, union_transform, current_generation);
  end

  // receiver stall pattern: free running, light random and heavy stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(40, 400);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // present one request and hold it until it is taken
  task automatic send_request(input logic rt, input logic [dht_pkg::MaskW-1:0] mask,
                              input logic tf, input logic [dht_pkg::GenW-1:0] seen);
    in_valid <= 1'b1;
    req_type <= rt;
    change_mask <= mask;
    change_transform <= tf;
    seen_generation <= seen;
    do @(posedge clk); while (in_stall);
    board.note_request(rt, mask, tf, seen);
  endtask

  task automatic hold_off(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // random request, queries mostly aimed around the live window
  task automatic send_random_request();
    logic [dht_pkg::GenW-1:0] g;
    logic [dht_pkg::MaskW-1:0] mask;
    logic [dht_pkg::GenW-1:0] seen;
    g = board.generation;
    mask = {$urandom, $urandom};
    seen = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 40) begin
      case ($urandom_range(0, 5))
        0: mask = '0;
        1: mask = ALL_DIRTY;
        2: mask = dht_pkg::MaskW'(1) << $urandom_range(0, dht_pkg::MaskW - 1);
        default: ;
      endcase
      send_request(dht_pkg::REQ_RECORD, mask, 1'($urandom), seen);
    end else begin
      case ($urandom_range(0, 9))
        0: seen = g;
        1: seen = g + $urandom_range(1, 4);
        2: seen = g - dht_pkg::GenW'(HISTORY_DEPTH);
        3: seen = g - dht_pkg::GenW'(HISTORY_DEPTH + 1);
        4: seen = '1;
        5: ;
        default: seen = g - $urandom_range(1, HISTORY_DEPTH);
      endcase
      send_request(dht_pkg::REQ_QUERY, mask, 1'($urandom), seen);
    end
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty history: current, far ahead, just ahead
    send_request(dht_pkg::REQ_QUERY, ALL_DIRTY, 1'b1, '0);
    send_request(dht_pkg::REQ_QUERY, '0, 1'b0, '1);
    send_request(dht_pkg::REQ_QUERY, '0, 1'b0, 64'd1);
    // records with extreme masks; seen field ignored
    send_request(dht_pkg::REQ_RECORD, ALL_DIRTY, 1'b1, '1);
    send_request(dht_pkg::REQ_RECORD, '0, 1'b0, '0);
    send_request(dht_pkg::REQ_RECORD, 64'h8000_0000_0000_0001, 1'b0,
                 64'h5555_5555_5555_5555);
    // partial union, full union, current; change fields ignored
    send_request(dht_pkg::REQ_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'd1);
    send_request(dht_pkg::REQ_QUERY, '0, 1'b0, 64'd0);
    send_request(dht_pkg::REQ_QUERY, '0, 1'b0, 64'd3);
    // fill the ring past its depth
    for (int i = 0; i < 14; i++)
      send_request(dht_pkg::REQ_RECORD, dht_pkg::MaskW'(1) << (i * 4 + 2), i[0], '0);
    // window exactly the ring depth, then one too old
    send_request(dht_pkg::REQ_QUERY, '0, 1'b0, 64'd1);
    send_request(dht_pkg::REQ_QUERY, '0, 1'b0, 64'd0);

    // random bursts with random gaps
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_random_request();
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) hold_off(gap);
    end

    // drain
    in_valid <= 1'b0;
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d records and %0d queries: %0d answered all dirty, %0d exact unions",
             board.records, board.queries, board.dirty_all, board.exact_unions);
    $display("final generation %0d, %0d field errors", board.generation, board.errors);
    if (board.errors == 0 && board.pending_answers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/dht_pkg.sv
design/dht_cell.sv
design/dirty_history_tracker.sv
tb/tb_dirty_history_tracker.sv
